/* rtl/core/edmf_pkg.sv */
package edmf_pkg;

  localparam int unsigned WIDTH_W    = 15;
  localparam int unsigned DIST_W     = 14;
  localparam int unsigned MIN_W      = 13;
  localparam int unsigned SCALE_W    = 16;
  localparam int unsigned PROD_W     = WIDTH_W + SCALE_W;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  typedef logic [WIDTH_W-1:0]    width_t;
  typedef logic [DIST_W-1:0]     dist_t;
  typedef logic [MIN_W-1:0]      min_dist_t;
  typedef logic [SCALE_W-1:0]    scale_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // no-echo sentinel, 999 cm in sixteenths
  localparam dist_t NO_ECHO_Q4 = 14'd15984;

  localparam min_dist_t MIN_DIST_RST = 13'd320;
  localparam dist_t     MAX_DIST_RST = 14'd6400;
  localparam scale_t    SCALE_RST    = 16'd17985;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_DIST = 2'd0,
    CFG_MAX_DIST = 2'd1,
    CFG_SCALE    = 2'd2
  } cfg_idx_e;

endpackage

/* rtl/core/edmf_if.sv */
interface edmf_in_if;
  import edmf_pkg::*;

  logic   valid;
  logic   ready;
  width_t echo_width_us;

  modport source (output valid, output echo_width_us, input ready);
  modport sink (input valid, input echo_width_us, output ready);
endinterface

interface edmf_out_if;
  import edmf_pkg::*;

  logic   valid;
  logic   ready;
  dist_t  median_distance_q4;
  logic   latest_valid;
  width_t measured_width;

  modport source (
    output valid, output median_distance_q4, output latest_valid, output measured_width,
    input ready
  );
  modport sink (
    input valid, input median_distance_q4, input latest_valid, input measured_width,
    output ready
  );
endinterface

/* rtl/core/edmf_median.sv */
module edmf_median #(
  parameter int unsigned Depth = 5
) (
  input  edmf_pkg::dist_t vals_i [Depth],
  output edmf_pkg::dist_t median_o
);
  import edmf_pkg::*;

  localparam int unsigned RankW   = $clog2(Depth);
  localparam int unsigned MidRank = Depth / 2;

  logic [RankW-1:0] rank [Depth];

  // rank of each entry, ties broken by position so every rank is unique
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      rank[i] = '0;
      for (int j = 0; j < Depth; j++) begin
        if (j != i) begin
          if ((vals_i[j] < vals_i[i]) || ((vals_i[j] == vals_i[i]) && (j < i))) begin
            rank[i] = rank[i] + RankW'(1);
          end
        end
      end
    end
  end

  always_comb begin
    median_o = '0;
    for (int i = 0; i < Depth; i++) begin
      if (rank[i] == RankW'(MidRank)) begin
        median_o = median_o | vals_i[i];
      end
    end
  end

endmodule

/* rtl/core/echo_distance_median5_filter_unit.sv */
// channel   dir  handshake     payload
// meas_i    in   valid/ready   echo_width_us
// res_o     out  valid/ready   median_distance_q4, latest_valid, measured_width
// cfg       in   cfg_we_i      cfg_idx_i, cfg_wdata_i
//
// one transaction per cycle sustained while the result is not stalled
// input register, then scale multiply, range check, ring write and median network
// into the result register
// history ring and pointer update when an item enters the result register
// asynchronous active-low reset clears both valid flags, loads the configuration defaults,
// and fills the ring with the no-echo sentinel
// a stalled result holds the input register; meas_i.ready drops only when both are full
module echo_distance_median5_filter_unit #(
  parameter int unsigned HISTORY_DEPTH = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  edmf_pkg::cfg_data_t  cfg_wdata_i,
  edmf_in_if.sink              meas_i,
  edmf_out_if.source           res_o
);
  import edmf_pkg::*;

  localparam int unsigned PtrW = $clog2(HISTORY_DEPTH);

  // configuration registers
  min_dist_t min_q;
  dist_t     max_q;
  scale_t    scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q   <= MIN_DIST_RST;
      max_q   <= MAX_DIST_RST;
      scale_q <= SCALE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_DIST: min_q   <= cfg_wdata_i[MIN_W-1:0];
        CFG_MAX_DIST: max_q   <= cfg_wdata_i[DIST_W-1:0];
        CFG_SCALE:    scale_q <= cfg_wdata_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake control
  logic   s1_valid_q, out_valid_q;
  logic   out_take, s1_free, s1_fire, in_fire;

  assign out_take = !out_valid_q || res_o.ready;
  assign s1_free  = !s1_valid_q || out_take;
  assign s1_fire  = s1_valid_q && out_take;
  assign in_fire  = meas_i.valid && s1_free;
  assign meas_i.ready = s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free) s1_valid_q <= meas_i.valid;
      if (out_take) out_valid_q <= s1_valid_q;
    end
  end

  // input register
  width_t s1_width_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) s1_width_q <= meas_i.echo_width_us;
  end

  // scale and range check
  logic [PROD_W-1:0]      prod;
  logic [WIDTH_W-1:0]     dist_full;
  logic                   in_range;
  dist_t                  new_dist;

  assign prod      = PROD_W'(s1_width_q) * PROD_W'(scale_q);
  assign dist_full = prod[PROD_W-1:FRAC_W];
  assign in_range  = (s1_width_q != '0) &&
                     (dist_full >= WIDTH_W'(min_q)) &&
                     (dist_full <= WIDTH_W'(max_q));
  assign new_dist  = in_range ? dist_full[DIST_W-1:0] : NO_ECHO_Q4;

  // history ring
  dist_t           ring_q    [HISTORY_DEPTH];
  dist_t           ring_next [HISTORY_DEPTH];
  logic [PtrW-1:0] ptr_q, ptr_d;
  dist_t           median;

  always_comb begin
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      ring_next[i] = ring_q[i];
    end
    ring_next[ptr_q] = new_dist;
    ptr_d = (ptr_q == PtrW'(HISTORY_DEPTH - 1)) ? '0 : ptr_q + PtrW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        ring_q[i] <= NO_ECHO_Q4;
      end
      ptr_q <= '0;
    end else if (s1_fire) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        ring_q[i] <= ring_next[i];
      end
      ptr_q <= ptr_d;
    end
  end

  edmf_median #(
    .Depth (HISTORY_DEPTH)
  ) u_median (
    .vals_i   (ring_next),
    .median_o (median)
  );

  // result register
  dist_t  out_median_q;
  logic   out_latest_q;
  width_t out_width_q;

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_median_q <= median;
      out_latest_q <= in_range;
      out_width_q  <= s1_width_q;
    end
  end

  assign res_o.valid              = out_valid_q;
  assign res_o.median_distance_q4 = out_median_q;
  assign res_o.latest_valid       = out_latest_q;
  assign res_o.measured_width     = out_width_q;

  // checks
  ptr_in_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= PtrW'(HISTORY_DEPTH - 1))
    else $error("ring pointer out of range");

  ptr_moves_only_on_write_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> $stable(ptr_q))
    else $error("ring pointer moved without a ring write");

  inrange_value_bounded_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && in_range) |-> (dist_full[WIDTH_W-1] == 1'b0))
    else $error("in-range distance wider than the ring entry");

  ready_low_only_when_full_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !meas_i.ready |-> (s1_valid_q && out_valid_q && !res_o.ready))
    else $error("input stalled with room in the pipeline");

  result_follows_input_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q)
    else $error("transaction lost before result register");

endmodule
